FILE: design/snh_pkg.sv
// Shared types and constants for the binomial heightmap smoothing block.
`timescale 1ns / 1ps

package snh_pkg;

    localparam int MAX_COLS     = 1024;
    localparam int SAMPLE_BITS  = 16;
    localparam int ROW_LIMIT    = 2046;
    localparam int COUNT_BITS   = 11;
    localparam int AMP_BITS     = 8;
    localparam int OUT_BITS     = 28;
    localparam int SUM_BITS     = SAMPLE_BITS + 4;
    localparam int PROD_BITS    = SUM_BITS + AMP_BITS + 1;
    localparam int LB_DEPTH     = MAX_COLS + 2;
    localparam int LB_ADDR_BITS = $clog2(LB_DEPTH);
    localparam int LB_WIDTH     = 2 * SAMPLE_BITS;
    localparam int PADDR_BITS   = 4;
    localparam int PDATA_BITS   = 32;

    localparam logic [1:0] REG_AMPLITUDE = 2'd0;
    localparam logic [1:0] REG_MAP_COLS  = 2'd1;
    localparam logic [1:0] REG_MAP_ROWS  = 2'd2;

    localparam logic [AMP_BITS-1:0]   AMPLITUDE_RESET = AMP_BITS'(1);
    localparam logic [COUNT_BITS-1:0] MAP_COLS_RESET  = COUNT_BITS'(1024);
    localparam logic [COUNT_BITS-1:0] MAP_ROWS_RESET  = COUNT_BITS'(1024);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic signed [OUT_BITS-1:0]    height_t;
    typedef logic [COUNT_BITS-1:0]         count_t;

    typedef struct packed {
        logic [AMP_BITS-1:0] amplitude;
        count_t              map_cols;
        count_t              map_rows;
    } cfg_t;

    typedef struct packed {
        sum_t sum;
        logic last;
    } sum_item_t;

endpackage

FILE: design/snh_noise_if.sv
// Input channel: one noise sample per request.
`timescale 1ns / 1ps

interface snh_noise_if;
    logic             valid;
    logic             ready;
    snh_pkg::sample_t noise_sample;

    modport source (output valid, output noise_sample, input ready);
    modport sink (input valid, input noise_sample, output ready);
endinterface

FILE: design/snh_height_if.sv
// Output channel: one height value per request.
`timescale 1ns / 1ps

interface snh_height_if;
    logic             valid;
    logic             ready;
    snh_pkg::height_t height_value;
    logic             last_point;

    modport source (output valid, output height_value, output last_point, input ready);
    modport sink (input valid, input height_value, input last_point, output ready);
endinterface

FILE: design/snh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module snh_ram #(
    parameter int  WIDTH     = 32,
    parameter int  DEPTH     = 1026,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/snh_regs.sv
// APB configuration registers: amplitude, map columns, map rows.
`timescale 1ns / 1ps

module snh_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [snh_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [snh_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [snh_pkg::PDATA_BITS-1:0]     prdata,
    output logic                               pready,
    output snh_pkg::cfg_t                      cfg
);
    import snh_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_AMPLITUDE: cfg_next.amplitude = pwdata[AMP_BITS-1:0];
                REG_MAP_COLS:  cfg_next.map_cols  = pwdata[COUNT_BITS-1:0];
                REG_MAP_ROWS:  cfg_next.map_rows  = pwdata[COUNT_BITS-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_AMPLITUDE: prdata = PDATA_BITS'(cfg_reg.amplitude);
            REG_MAP_COLS:  prdata = PDATA_BITS'(cfg_reg.map_cols);
            REG_MAP_ROWS:  prdata = PDATA_BITS'(cfg_reg.map_rows);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amplitude <= AMPLITUDE_RESET;
            cfg_reg.map_cols  <= MAP_COLS_RESET;
            cfg_reg.map_rows  <= MAP_ROWS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/snh_scan.sv
// Raster position counters, line buffer memory access, 3x3 window and weighted sum.
`timescale 1ns / 1ps

module snh_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  snh_pkg::cfg_t         cfg,
    snh_noise_if.sink             noise_in,
    output logic                  sum_valid,
    input  logic                  sum_ready,
    output snh_pkg::sum_item_t    sum_item
);
    import snh_pkg::*;

    // position counters
    count_t col_count_reg;
    count_t col_count_next;
    count_t row_count_reg;
    count_t row_count_next;
    count_t cols_eff;
    count_t rows_eff;
    count_t last_col;
    count_t last_row;
    count_t col_cur;
    count_t row_cur;
    logic   accept;

    // stage 1: memory data arrives
    logic                    s1_valid_reg;
    logic [LB_ADDR_BITS-1:0] s1_addr_reg;
    sample_t                 s1_sample_reg;
    logic                    s1_emit_reg;
    logic                    s1_last_reg;
    logic                    s1_en;
    logic                    s1_adv;

    // stage 2: weighted sum
    logic      s2_valid_reg;
    sum_item_t s2_item_reg;
    logic      s2_en;

    sample_t                 win_reg [6];
    logic [LB_ADDR_BITS-1:0] rd_addr;
    logic [LB_WIDTH-1:0]     rd_data;
    sample_t                 top;
    sample_t                 mid;
    sum_t                    corners;
    sum_t                    sides;
    sum_t                    sum_val;

    assign cols_eff = (cfg.map_cols > COUNT_BITS'(MAX_COLS)) ? COUNT_BITS'(MAX_COLS)
                                                             : cfg.map_cols;
    assign rows_eff = (cfg.map_rows > COUNT_BITS'(ROW_LIMIT)) ? COUNT_BITS'(ROW_LIMIT)
                                                              : cfg.map_rows;
    assign last_col = cols_eff + COUNT_BITS'(1);
    assign last_row = rows_eff + COUNT_BITS'(1);
    assign col_cur  = (col_count_reg > last_col) ? last_col : col_count_reg;
    assign row_cur  = (row_count_reg > last_row) ? last_row : row_count_reg;

    assign s2_en          = !s2_valid_reg || sum_ready;
    assign s1_en          = !s1_valid_reg || s2_en;
    assign s1_adv         = s1_valid_reg && s2_en;
    assign noise_in.ready = s1_en;
    assign accept         = noise_in.valid && s1_en;

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (col_cur >= last_col)
            begin
                col_count_next = '0;
                row_count_next = (row_cur >= last_row) ? '0 : row_cur + COUNT_BITS'(1);
            end
            else
            begin
                col_count_next = col_cur + COUNT_BITS'(1);
                row_count_next = row_cur;
            end
        end
    end

    // A held stage 1 re-reads its own entry; it is not written until the stage advances.
    assign rd_addr = (s1_valid_reg && !s2_en) ? s1_addr_reg : LB_ADDR_BITS'(col_cur);

    // Entry holds {row two above, row above} for one column.
    snh_ram #(
        .WIDTH (LB_WIDTH),
        .DEPTH (LB_DEPTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_addr_reg),
        .wdata ({mid, s1_sample_reg}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign top = rd_data[LB_WIDTH-1:SAMPLE_BITS];
    assign mid = rd_data[SAMPLE_BITS-1:0];

    always_comb
    begin
        corners = SUM_BITS'(win_reg[0]) + SUM_BITS'(top) + SUM_BITS'(win_reg[4])
                + SUM_BITS'(s1_sample_reg);
        sides   = SUM_BITS'(win_reg[1]) + SUM_BITS'(win_reg[5]) + SUM_BITS'(win_reg[2])
                + SUM_BITS'(mid);
        sum_val = corners + (sides <<< 1) + (SUM_BITS'(win_reg[3]) <<< 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            if (s1_en)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            end
            if (s1_adv)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= top;
                win_reg[2] <= win_reg[3];
                win_reg[3] <= mid;
                win_reg[4] <= win_reg[5];
                win_reg[5] <= s1_sample_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg   <= LB_ADDR_BITS'(col_cur);
            s1_sample_reg <= noise_in.noise_sample;
            s1_emit_reg   <= (row_cur >= COUNT_BITS'(2)) && (col_cur >= COUNT_BITS'(2));
            s1_last_reg   <= (row_cur == last_row) && (col_cur == last_col);
        end
        if (s1_adv)
        begin
            s2_item_reg.sum  <= sum_val;
            s2_item_reg.last <= s1_last_reg;
        end
    end

    assign sum_valid = s2_valid_reg;
    assign sum_item  = s2_item_reg;

endmodule

FILE: design/snh_scale.sv
// Amplitude multiply into the output register.
`timescale 1ns / 1ps

module snh_scale (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [snh_pkg::AMP_BITS-1:0]        amplitude,
    input  logic                                sum_valid,
    output logic                                sum_ready,
    input  snh_pkg::sum_item_t                  sum_item,
    snh_height_if.source                        height_out
);
    import snh_pkg::*;

    logic                        out_valid_reg;
    height_t                     height_reg;
    logic                        last_reg;
    logic signed [PROD_BITS-1:0] prod;

    assign sum_ready = !out_valid_reg || height_out.ready;
    assign prod      = sum_item.sum * $signed({1'b0, amplitude});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sum_ready)
        begin
            out_valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_ready && sum_valid)
        begin
            height_reg <= OUT_BITS'(prod);
            last_reg   <= sum_item.last;
        end
    end

    assign height_out.valid        = out_valid_reg;
    assign height_out.height_value = height_reg;
    assign height_out.last_point   = last_reg;

endmodule

FILE: design/smooth_noise_heightmap.sv
// 3x3 binomial smoothing of a noise stream into height values.
//
// noise_in takes signed Q1.15 samples in raster order over the padded grid,
// (map_rows+2) rows by (map_cols+2) columns. height_out gives one result per
// interior point: the 1-2-1 weighted sum (16x the smoothed value) times
// amplitude, with last_point set on the final interior point. Border samples
// give no result. After the last padded sample the next one starts a new map.
// Throughput is one sample per clock while height_out does not stall; each
// sample does one read and one write of the shared line buffer memory, one column entry apiece.
// A result passes through the memory read, the sum register and the
// multiply/output register on its way to height_out.
// A stall on height_out fills the bubbles in the pipe first; noise_in.ready
// drops only when all stages hold data.
// Reset clears the counters, window and pipe valids and loads amplitude 1,
// map_cols 1024, map_rows 1024; the line buffer needs no clearing.
// Write registers over APB only while the block is idle.
`timescale 1ns / 1ps

module smooth_noise_heightmap (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [snh_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [snh_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [snh_pkg::PDATA_BITS-1:0]  prdata,
    output logic                            pready,
    snh_noise_if.sink                       noise_in,
    snh_height_if.source                    height_out
);
    import snh_pkg::*;

    cfg_t      cfg;
    logic      sum_valid;
    logic      sum_ready;
    sum_item_t sum_item;

    snh_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    snh_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .noise_in  (noise_in),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum_item  (sum_item)
    );

    snh_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .amplitude  (cfg.amplitude),
        .sum_valid  (sum_valid),
        .sum_ready  (sum_ready),
        .sum_item   (sum_item),
        .height_out (height_out)
    );

endmodule
